/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Whenever pre holds, post must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

/* rtl/wrp_pkg.sv */
// Types and constants for the RIFF/WAVE header parser.
// No dependencies; used by wrp_parse_core, the top level and the testbench.
package wrp_pkg;

   localparam logic [31:0] ID_RIFF = 32'h5249_4646;
   localparam logic [31:0] ID_WAVE = 32'h5741_5645;
   localparam logic [31:0] ID_FMT  = 32'h666D_7420;
   localparam logic [31:0] ID_DATA = 32'h6461_7461;

   localparam logic [4:0]  FMT_SIZE_SHORT = 5'd16;
   localparam logic [4:0]  FMT_SIZE_LONG  = 5'd18;
   localparam logic [31:0] CHUNK_HDR_BYTES = 32'd8;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_FORMAT = 2'd1;
   localparam logic [1:0] KIND_FOUND  = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NOT_WAVE = 3'd1;
   localparam logic [2:0] ERR_NO_FMT   = 3'd2;
   localparam logic [2:0] ERR_FMT_SIZE = 3'd3;
   localparam logic [2:0] ERR_NO_DATA  = 3'd4;

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b000_0001,
      PH_HEAD  = 7'b000_0010,
      PH_FMT   = 7'b000_0100,
      PH_CHUNK = 7'b000_1000,
      PH_SKIP  = 7'b001_0000,
      PH_DATA  = 7'b010_0000,
      PH_DONE  = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic [7:0]  byte_in;
      logic        first_byte;
      logic [30:0] file_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  byte_value;
      logic        last_data;
      logic        truncated;
      logic [15:0] format_tag;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic [31:0] data_length;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] position;
      logic [30:0] length_latched;
      logic [63:0] header_shift;
      logic [4:0]  fmt_body_size;
      logic [63:0] format_regs;
      logic [31:0] bytes_remaining;
      logic        riff_seen;
      logic [15:0] bits_latch;
   } state_type;

endpackage

/* rtl/wav_riff_header_parser_unit.sv */
// RIFF/WAVE PCM header parser, one file byte per req beat.
// A result appears on rsp in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while rsp_ready is high; the single output
// register is refilled in the cycle it is emptied, so only rsp back-pressure stalls.
// Reset (synchronous, active high) puts the parser idle and empties the output.
`include "assert_macros.svh"
module wav_riff_header_parser_unit import wrp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // parse state, updated only on an accepted byte
   state_type st_ff;
   state_type st_in;

   // output register: holds at most one result beat
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic    step_valid;
   rsp_type step_data;
   logic    req_fire;

   // beats watched by the checks below
   logic    err_beat;
   logic    data_beat;

   // all per-byte decisions live in the core; the top only holds registers
   wrp_parse_core u_core (
      .st        (st_ff),
      .req       (req_data),
      .nxt       (st_in),
      .res_valid (step_valid),
      .res       (step_data)
   );

   // a new byte may enter whenever the output slot is free or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // whole parse state in one register; the phase starts at PH_IDLE, every other field at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase           <= PH_IDLE;
         st_ff.position        <= 32'd0;
         st_ff.length_latched  <= 31'd0;
         st_ff.header_shift    <= 64'd0;
         st_ff.fmt_body_size   <= 5'd0;
         st_ff.format_regs     <= 64'd0;
         st_ff.bytes_remaining <= 32'd0;
         st_ff.riff_seen       <= 1'b0;
         st_ff.bits_latch      <= 16'd0;
      end else if (req_fire) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= step_valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= step_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign err_beat  = req_fire && step_valid && step_data.result_kind == KIND_ERROR;
   assign data_beat = req_fire && step_valid && step_data.result_kind == KIND_DATA;

   // an error beat always ends the parse
   `ASSERT_NEXT(a_error_ends, clock, reset, err_beat, st_ff.phase == PH_DONE)
   // a finished parse ignores bytes until the next first byte
   `ASSERT_NEXT(a_done_silent, clock, reset, req_fire && st_ff.phase == PH_DONE && !req_data.first_byte, !rsp_valid_ff)
   // payload bytes are only produced while passing the data chunk through
   `ASSERT_ALWAYS(a_data_phase, clock, reset, !data_beat || st_ff.phase == PH_DATA)

endmodule

/* rtl/wrp_parse_core.sv */
// Next-state and result logic for one file byte of the RIFF/WAVE parser.
// Purely combinational; depends on wrp_pkg.
module wrp_parse_core import wrp_pkg::*; (
   input  state_type st,
   input  req_type   req,
   output state_type nxt,
   output logic      res_valid,
   output rsp_type   res
);

   logic        active;
   phase_type   cur_phase;
   logic [31:0] pos;
   logic [63:0] hs;
   logic [31:0] size_le;
   logic [4:0]  fmt_idx;
   logic [5:0]  fmt_off;
   logic [15:0] bits_now;
   logic [33:0] fmt_end_sum;
   logic [33:0] skip_end_sum;
   logic [33:0] len_wide;
   logic [32:0] data_next;
   logic [31:0] br_dec;
   logic        last;
   logic        trunc;

   always_comb begin
      active    = req.first_byte || (st.phase != PH_IDLE && st.phase != PH_DONE);
      cur_phase = req.first_byte ? PH_HEAD : st.phase;
      pos       = req.first_byte ? 32'd0 : st.position + 32'd1;
      hs        = req.first_byte ? {56'd0, req.byte_in} : {st.header_shift[55:0], req.byte_in};
      // little-endian size field of the newest four bytes
      size_le   = {hs[7:0], hs[15:8], hs[23:16], hs[31:24]};
      fmt_off   = pos[5:0] - 6'd20;
      fmt_idx   = fmt_off[4:0];
      bits_now  = (fmt_idx == 5'd15) ? {hs[7:0], hs[15:8]} : st.bits_latch;
      len_wide  = {3'd0, st.length_latched};
      fmt_end_sum  = {2'd0, pos} + 34'd9;
      skip_end_sum = {2'd0, pos} + {2'd0, size_le} + 34'd9;
      data_next = {1'b0, pos} + 33'd1;
      br_dec    = (st.bytes_remaining != 32'd0) ? st.bytes_remaining - 32'd1 : 32'd0;
      last      = (br_dec == 32'd0);
      trunc     = !last && (data_next >= {2'd0, st.length_latched});

      nxt       = st;
      res_valid = 1'b0;
      res       = '0;

      if (active) begin
         nxt.position     = pos;
         nxt.header_shift = hs;
         if (req.first_byte) begin
            nxt.length_latched  = req.file_length;
            nxt.fmt_body_size   = 5'd0;
            nxt.format_regs     = 64'd0;
            nxt.bytes_remaining = 32'd0;
            nxt.riff_seen       = 1'b0;
            nxt.bits_latch      = 16'd0;
            nxt.phase           = PH_HEAD;
         end

         case (cur_phase)
            PH_HEAD: begin
               if (pos == 32'd3) begin
                  nxt.riff_seen = (hs[31:0] == ID_RIFF);
               end else if (pos == 32'd11) begin
                  if (!st.riff_seen || hs[31:0] != ID_WAVE) begin
                     res_valid      = 1'b1;
                     res.result_kind = KIND_ERROR;
                     res.error_code = ERR_NOT_WAVE;
                     nxt.phase      = PH_DONE;
                  end
               end else if (pos == 32'd19) begin
                  if (hs[63:32] != ID_FMT) begin
                     res_valid      = 1'b1;
                     res.result_kind = KIND_ERROR;
                     res.error_code = ERR_NO_FMT;
                     nxt.phase      = PH_DONE;
                  end else if (size_le != {27'd0, FMT_SIZE_SHORT} &&
                               size_le != {27'd0, FMT_SIZE_LONG}) begin
                     res_valid      = 1'b1;
                     res.result_kind = KIND_ERROR;
                     res.error_code = ERR_FMT_SIZE;
                     nxt.phase      = PH_DONE;
                  end else begin
                     nxt.fmt_body_size = size_le[4:0];
                     nxt.phase         = PH_FMT;
                  end
               end
            end
            PH_FMT: begin
               if (fmt_idx == 5'd7) begin
                  nxt.format_regs = hs;
               end
               nxt.bits_latch = bits_now;
               if (fmt_idx + 5'd1 >= st.fmt_body_size) begin
                  res_valid = 1'b1;
                  if (!(fmt_end_sum < len_wide)) begin
                     res.result_kind = KIND_ERROR;
                     res.error_code  = ERR_NO_DATA;
                     nxt.phase       = PH_DONE;
                  end else begin
                     res.result_kind     = KIND_FORMAT;
                     res.format_tag      = {st.format_regs[55:48], st.format_regs[63:56]};
                     res.channel_count   = {st.format_regs[39:32], st.format_regs[47:40]};
                     res.sample_rate     = {st.format_regs[7:0], st.format_regs[15:8],
                                            st.format_regs[23:16], st.format_regs[31:24]};
                     res.bits_per_sample = bits_now;
                     nxt.phase           = PH_CHUNK;
                     nxt.bytes_remaining = CHUNK_HDR_BYTES;
                  end
               end
            end
            PH_CHUNK: begin
               if (st.bytes_remaining > 32'd1) begin
                  nxt.bytes_remaining = st.bytes_remaining - 32'd1;
               end else if (hs[63:32] == ID_DATA) begin
                  res_valid       = 1'b1;
                  res.result_kind = KIND_FOUND;
                  res.data_length = {size_le[31:1], 1'b0};
                  if (size_le[31:1] == 31'd0) begin
                     res.last_data = 1'b1;
                     nxt.phase     = PH_DONE;
                  end else begin
                     nxt.bytes_remaining = {size_le[31:1], 1'b0};
                     nxt.phase           = PH_DATA;
                  end
               end else if (!(skip_end_sum < len_wide)) begin
                  res_valid       = 1'b1;
                  res.result_kind = KIND_ERROR;
                  res.error_code  = ERR_NO_DATA;
                  nxt.phase       = PH_DONE;
               end else if (size_le == 32'd0) begin
                  nxt.bytes_remaining = CHUNK_HDR_BYTES;
               end else begin
                  nxt.bytes_remaining = size_le;
                  nxt.phase           = PH_SKIP;
               end
            end
            PH_SKIP: begin
               if (br_dec == 32'd0) begin
                  nxt.bytes_remaining = CHUNK_HDR_BYTES;
                  nxt.phase           = PH_CHUNK;
               end else begin
                  nxt.bytes_remaining = br_dec;
               end
            end
            PH_DATA: begin
               nxt.bytes_remaining = br_dec;
               res_valid       = 1'b1;
               res.result_kind = KIND_DATA;
               res.byte_value  = req.byte_in;
               res.last_data   = last || trunc;
               res.truncated   = trunc;
               if (last || trunc) begin
                  nxt.phase = PH_DONE;
               end
            end
            default: begin
               nxt.phase = PH_DONE;
            end
         endcase
      end
   end

endmodule

/* dv/wrp_tb_pkg.sv */
// Scoreboard for the RIFF/WAVE header parser testbench.
// Depends on wrp_pkg for the beat types, chunk IDs and result codes.
package wrp_tb_pkg;
   import wrp_pkg::*;

   class wav_parse_board;
      rsp_type     pending_results[$];
      int          errors;
      int          live_bytes;
      // shadow of the parser state
      phase_type   ph;
      logic [31:0] pos;
      logic [30:0] len;
      logic [63:0] shreg;
      logic [4:0]  fmt_len;
      logic [63:0] fmt_regs;
      logic [31:0] remain;
      logic        riff_ok;
      logic [15:0] bps_latch;

      function new();
         errors     = 0;
         live_bytes = 0;
         clear_state();
      endfunction

      function void clear_state();
         ph        = PH_IDLE;
         pos       = '0;
         len       = '0;
         shreg     = '0;
         fmt_len   = '0;
         fmt_regs  = '0;
         remain    = '0;
         riff_ok   = 1'b0;
         bps_latch = '0;
      endfunction

      function logic [31:0] swap32(logic [31:0] w);
         return {w[7:0], w[15:8], w[23:16], w[31:24]};
      endfunction

      // another chunk header and at least one byte after it must fit within length
      function bit header_fits(logic [63:0] next_pos);
         return next_pos + 64'd8 < 64'(len);
      endfunction

      function void push_error(logic [2:0] code);
         rsp_type res;
         res            = '0;
         res.result_kind = KIND_ERROR;
         res.error_code = code;
         pending_results.push_back(res);
         ph = PH_DONE;
      endfunction

      // Notes one accepted req beat and queues the result it causes, if any.
      function void predict_byte(req_type beat);
         rsp_type     res;
         logic [31:0] sz;
         logic [31:0] idx;
         logic [31:0] dl;
         logic        last;
         logic        trunc;
         res = '0;
         if (beat.first_byte) begin
            clear_state();
            len = beat.file_length;
            ph  = PH_HEAD;
         end else if (ph == PH_IDLE || ph == PH_DONE) begin
            return;
         end else begin
            pos = pos + 32'd1;
         end
         live_bytes++;
         shreg = {shreg[55:0], beat.byte_in};
         case (ph)
            PH_HEAD: begin
               if (pos == 32'd3) begin
                  riff_ok = (shreg[31:0] == ID_RIFF);
               end else if (pos == 32'd11) begin
                  if (!riff_ok || shreg[31:0] != ID_WAVE) push_error(ERR_NOT_WAVE);
               end else if (pos == 32'd19) begin
                  sz = swap32(shreg[31:0]);
                  if (shreg[63:32] != ID_FMT) begin
                     push_error(ERR_NO_FMT);
                  end else if (sz != 32'(FMT_SIZE_SHORT) && sz != 32'(FMT_SIZE_LONG)) begin
                     push_error(ERR_FMT_SIZE);
                  end else begin
                     fmt_len = sz[4:0];
                     ph      = PH_FMT;
                  end
               end
            end
            PH_FMT: begin
               idx = pos - 32'd20;
               if (idx == 32'd7) fmt_regs = shreg;
               else if (idx == 32'd15) bps_latch = {shreg[7:0], shreg[15:8]};
               if (idx + 32'd1 >= 32'(fmt_len)) begin
                  if (!header_fits(64'(pos) + 64'd1)) begin
                     push_error(ERR_NO_DATA);
                  end else begin
                     res.result_kind     = KIND_FORMAT;
                     res.format_tag      = {fmt_regs[55:48], fmt_regs[63:56]};
                     res.channel_count   = {fmt_regs[39:32], fmt_regs[47:40]};
                     res.sample_rate     = swap32(fmt_regs[31:0]);
                     res.bits_per_sample = bps_latch;
                     pending_results.push_back(res);
                     ph     = PH_CHUNK;
                     remain = CHUNK_HDR_BYTES;
                  end
               end
            end
            PH_CHUNK: begin
               if (remain > 32'd1) begin
                  remain = remain - 32'd1;
               end else begin
                  sz = swap32(shreg[31:0]);
                  if (shreg[63:32] == ID_DATA) begin
                     dl = {sz[31:1], 1'b0};
                     res.result_kind = KIND_FOUND;
                     res.data_length = dl;
                     if (dl == '0) begin
                        res.last_data = 1'b1;
                        ph = PH_DONE;
                     end else begin
                        remain = dl;
                        ph     = PH_DATA;
                     end
                     pending_results.push_back(res);
                  end else if (!header_fits(64'(pos) + 64'd1 + 64'(sz))) begin
                     push_error(ERR_NO_DATA);
                  end else if (sz == '0) begin
                     remain = CHUNK_HDR_BYTES;
                  end else begin
                     remain = sz;
                     ph     = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (remain > '0) remain = remain - 32'd1;
               if (remain == '0) begin
                  ph     = PH_CHUNK;
                  remain = CHUNK_HDR_BYTES;
               end
            end
            PH_DATA: begin
               if (remain > '0) remain = remain - 32'd1;
               last  = (remain == '0);
               trunc = !last && (64'(pos) + 64'd1 >= 64'(len));
               res.result_kind = KIND_DATA;
               res.byte_value  = beat.byte_in;
               res.last_data   = last || trunc;
               res.truncated   = trunc;
               if (last || trunc) ph = PH_DONE;
               pending_results.push_back(res);
            end
            default: ph = PH_DONE;
         endcase
      endfunction

      function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Compares one accepted rsp beat with the oldest queued result.
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         cmp_field("result_kind", want.result_kind, got.result_kind);
         cmp_field("byte_value", want.byte_value, got.byte_value);
         cmp_field("last_data", want.last_data, got.last_data);
         cmp_field("truncated", want.truncated, got.truncated);
         cmp_field("format_tag", want.format_tag, got.format_tag);
         cmp_field("channel_count", want.channel_count, got.channel_count);
         cmp_field("sample_rate", want.sample_rate, got.sample_rate);
         cmp_field("bits_per_sample", want.bits_per_sample, got.bits_per_sample);
         cmp_field("data_length", want.data_length, got.data_length);
         cmp_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

endpackage

/* dv/wav_riff_header_parser_unit_tb.sv */
// Testbench for wav_riff_header_parser_unit: streams whole and damaged WAV files.
// Depends on wrp_pkg (beat types, IDs) and wrp_tb_pkg (scoreboard).
module wav_riff_header_parser_unit_tb;
   import wrp_pkg::*;
   import wrp_tb_pkg::*;

   // cycles with no beat on either channel before the run is called hung
   localparam int STALL_LIMIT = 2000;
   localparam int LIVE_TARGET = 1500;

   typedef logic [7:0] octet_q[$];

   // how each generated file is built or damaged
   typedef enum int {
      FILE_GOOD,
      FILE_TRUNCATED,
      FILE_EMPTY_DATA,
      FILE_BAD_RIFF,
      FILE_BAD_WAVE,
      FILE_BAD_FMT_ID,
      FILE_BAD_FMT_SIZE,
      FILE_NO_ROOM,
      FILE_SKIP_OVER,
      FILE_CUT_SHORT,
      FILE_WIDE_LENGTH
   } file_shape_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // idling knobs, in percent of cycles
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   // long rsp hold-off, counted down by the receiver process
   int hold_off_cycles    = 0;
   int quiet_cycles       = 0;

   wav_parse_board parse_board = new();

   wav_riff_header_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver: random stalls, or a solid hold-off when one is asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Monitor and watchdog. Results check before the new byte is noted: a
   // result never comes from the byte accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) parse_board.check_result(rsp_data);
         if (req_valid && req_ready) parse_board.predict_byte(req_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // One req beat; returns at the edge where it is taken.
   task automatic send_beat(input logic [7:0] b, input logic first, input logic [30:0] flen);
      req_type beat;
      beat.byte_in     = b;
      beat.first_byte  = first;
      beat.file_length = flen;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   // Length rides on the first byte only; later beats carry junk there.
   task automatic send_file(input octet_q bytes_in, input logic [30:0] flen);
      foreach (bytes_in[i]) begin
         send_beat(bytes_in[i], i == 0, (i == 0) ? flen : 31'($urandom));
      end
   endtask

   function automatic void push_word(ref octet_q q, input logic [31:0] w, input bit big_end);
      for (int k = 0; k < 4; k++) begin
         q.push_back(big_end ? w[31 - 8 * k -: 8] : w[8 * k +: 8]);
      end
   endfunction

   function automatic void build_file(input file_shape_type shape, input int dmin,
                                      input int dmax, output octet_q q,
                                      output logic [30:0] flen);
      logic [31:0] fsz;
      logic [31:0] dsz;
      logic [31:0] csz;
      logic [31:0] cid;
      logic [7:0]  flip;
      int          nskip;
      int          data_start;
      int          nbody;
      q     = {};
      fsz   = $urandom_range(1) ? 32'(FMT_SIZE_LONG) : 32'(FMT_SIZE_SHORT);
      nskip = (shape == FILE_EMPTY_DATA) ? 0 : $urandom_range(2);
      if (shape == FILE_SKIP_OVER) nskip = 1;
      flip  = 8'($urandom_range(1, 255));
      push_word(q, ID_RIFF, 1'b1);
      push_word(q, $urandom, 1'b0);
      push_word(q, ID_WAVE, 1'b1);
      push_word(q, ID_FMT, 1'b1);
      push_word(q, fsz, 1'b0);
      repeat (fsz) q.push_back(8'($urandom));
      for (int k = 0; k < nskip; k++) begin
         cid = $urandom;
         if (cid == ID_DATA) cid = cid ^ 32'd1;
         csz = $urandom_range(5);
         if (shape == FILE_SKIP_OVER) begin
            // past the scan limit, the all-ones size included
            csz = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h0001_0000);
         end
         push_word(q, cid, 1'b1);
         push_word(q, csz, 1'b0);
         repeat ((shape == FILE_SKIP_OVER) ? 4 : csz) q.push_back(8'($urandom));
      end
      if (shape != FILE_SKIP_OVER) begin
         if (shape == FILE_EMPTY_DATA) dsz = $urandom_range(1);
         else if (shape == FILE_WIDE_LENGTH) dsz = $urandom;
         else dsz = $urandom_range(dmin, dmax);
         push_word(q, ID_DATA, 1'b1);
         push_word(q, dsz, 1'b0);
         data_start = q.size();
         nbody = (dsz > 32'd24 && shape == FILE_WIDE_LENGTH) ? 24 : int'(dsz);
         repeat (nbody) q.push_back(8'($urandom));
         repeat ($urandom_range(2)) q.push_back(8'($urandom));
      end
      flen = 31'(q.size());
      case (shape)
         FILE_TRUNCATED: begin
            if (dsz >= 32'd2) flen = 31'(data_start + $urandom_range(1, int'(dsz) - 1));
         end
         FILE_BAD_RIFF: q[$urandom_range(3)] ^= flip;
         FILE_BAD_WAVE: q[$urandom_range(11, 8)] ^= flip;
         FILE_BAD_FMT_ID: q[$urandom_range(15, 12)] ^= flip;
         FILE_BAD_FMT_SIZE: begin
            // low five bits may still read 16 or 18; the whole word must count
            q[16] = 8'($urandom);
            if (q[16] == 8'd16 || q[16] == 8'd18) q[16] = 8'd17;
            if ($urandom_range(1)) q[$urandom_range(19, 17)] = 8'($urandom_range(1, 255));
         end
         FILE_NO_ROOM: flen = 31'($urandom_range(0, 28 + int'(fsz)));
         FILE_CUT_SHORT: q = q[0 : $urandom_range(q.size() - 1)];
         FILE_WIDE_LENGTH: flen = 31'($urandom);
         default: ;
      endcase
   endfunction

   initial begin
      octet_q         file_bytes;
      logic [30:0]    flen;
      file_shape_type shape;
      int             n;
      int             pick;
      n = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: a byte with no file open, an all-ones header at the
      // largest length (not RIFF), then a byte after the error.
      send_beat(8'hFF, 1'b0, 31'h7FFF_FFFF);
      for (int i = 0; i < 12; i++) send_beat(8'hFF, i == 0, 31'h7FFF_FFFF);
      send_beat(8'h00, 1'b0, 31'h0);

      // File by file. The first pass walks every shape once; file 12
      // fills the block under a long rsp hold-off.
      while (parse_board.live_bytes < LIVE_TARGET) begin
         if (n == 12) begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
            hold_off_cycles    = 300;
            build_file(FILE_GOOD, 32, 40, file_bytes, flen);
         end else begin
            case ((n / 4) % 4)
               0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
               1: begin sender_idle_pct = 74; receiver_stall_pct = 0;  end
               2: begin sender_idle_pct = 0;  receiver_stall_pct = 74; end
               default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
            endcase
            if (n <= int'(FILE_WIDE_LENGTH)) begin
               shape = file_shape_type'(n);
            end else begin
               pick = $urandom_range(99);
               if (pick < 55) shape = FILE_GOOD;
               else if (pick < 65) shape = FILE_TRUNCATED;
               else if (pick < 70) shape = FILE_EMPTY_DATA;
               else if (pick < 73) shape = FILE_BAD_RIFF;
               else if (pick < 76) shape = FILE_BAD_WAVE;
               else if (pick < 79) shape = FILE_BAD_FMT_ID;
               else if (pick < 83) shape = FILE_BAD_FMT_SIZE;
               else if (pick < 87) shape = FILE_NO_ROOM;
               else if (pick < 91) shape = FILE_SKIP_OVER;
               else if (pick < 96) shape = FILE_CUT_SHORT;
               else shape = FILE_WIDE_LENGTH;
            end
            build_file(shape, 0, 24, file_bytes, flen);
         end
         send_file(file_bytes, flen);
         // stray bytes between files, mostly landing on a finished parse
         repeat ($urandom_range(2)) send_beat(8'($urandom), 1'b0, 31'($urandom));
         n++;
      end
      req_valid <= 1'b0;

      // drain: let the last beat reach the scoreboard, then every result
      @(posedge clock);
      while (parse_board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (parse_board.errors == 0 && parse_board.pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
